FILE: src/clock_synth_divider_calc_defines.svh
// Assertion macros for the divider calculator modules.
// No dependencies. Files that assert take this header by include.
`ifndef CLOCK_SYNTH_DIVIDER_CALC_DEFINES_SVH
`define CLOCK_SYNTH_DIVIDER_CALC_DEFINES_SVH
`ifndef SYNTHESIS
// Check that holds at every clock edge outside reset.
`define CSCD_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	prop) else $error("cscd assertion failed");
// Check that a condition is followed by another in the next cycle.
`define CSCD_ASSERT_NEXT(lbl, ante, cons) lbl: assert property (@(posedge clk) \
	disable iff (!arst_n) (ante) |=> (cons)) else $error("cscd assertion failed");
`else
`define CSCD_ASSERT(lbl, prop)
`define CSCD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: src/cscd_pkg.sv
// Types and constants of the clock synthesizer divider calculator.
// No dependencies; used by the serializer and the top level.
package cscd_pkg;

	localparam logic [29:0] VCO_TARGET = 30'd900000000;
	localparam logic [19:0] FRAC_DEN   = 20'hFFFFF;
	localparam logic [7:0]  PLLA_BASE  = 8'd26;
	localparam logic [7:0]  MS_BASE    = 8'd42;
	localparam logic [7:0]  MS_STRIDE  = 8'd18;
	localparam logic [7:0]  RST_ADDR   = 8'd177;
	localparam logic [7:0]  RST_PLLA   = 8'h20;
	localparam logic [7:0]  FRAC_HI    = 8'hF0;
	localparam logic [17:0] P1_OFFSET  = 18'd512;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_CRYSTAL  = 3'd0,
		CFG_MIN_HZ   = 3'd1,
		CFG_MAX_HZ   = 3'd2,
		CFG_DIV_MIN  = 3'd3,
		CFG_DIV_MAX  = 3'd4,
		CFG_MULT_MIN = 3'd5,
		CFG_MULT_MAX = 3'd6,
		CFG_RST_EN   = 3'd7
	} cfg_idx_t;

	// Packed divider parameters of one request, handed to the serializer.
	typedef struct packed {
		logic [7:0]  base;
		logic [2:0]  rlog;
		logic [17:0] p1;
		logic [19:0] p2;
		logic [17:0] mp1;
	} ser_rec_t;

endpackage

FILE: src/cscd_div_cell.sv
// One restoring division step, registered, with a side payload.
// No dependencies; instantiated in a row by cscd_div_chain.
module cscd_div_cell #(
	parameter int DW = 32,
	parameter int NW = 30,
	parameter int PW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_in,
	input  logic [DW-1:0] rem_in,
	input  logic [NW-1:0] num_in,
	input  logic [NW-1:0] quo_in,
	input  logic [DW-1:0] d_in,
	input  logic [PW-1:0] pl_in,
	output logic          v_out,
	output logic [DW-1:0] rem_out,
	output logic [NW-1:0] num_out,
	output logic [NW-1:0] quo_out,
	output logic [DW-1:0] d_out,
	output logic [PW-1:0] pl_out
);

	logic [DW:0] trial;
	logic [DW:0] diff;
	logic        ge;

	// Bring down the next dividend bit and try the subtraction.
	always_comb begin
		trial = {rem_in, num_in[NW-1]};
		diff  = trial - {1'b0, d_in};
		ge    = trial >= {1'b0, d_in};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out <= ge ? diff[DW-1:0] : trial[DW-1:0];
			num_out <= num_in << 1;
			quo_out <= {quo_in[NW-2:0], ge};
			d_out   <= d_in;
			pl_out  <= pl_in;
		end
	end

endmodule

FILE: src/cscd_div_chain.sv
// Row of NW division cells: one quotient bit per cell; items step along while en is high.
// Depends on cscd_div_cell.
module cscd_div_chain #(
	parameter int DW = 32,
	parameter int NW = 30,
	parameter int PW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_in,
	input  logic [DW-1:0] rem_in,
	input  logic [NW-1:0] num_in,
	input  logic [DW-1:0] d_in,
	input  logic [PW-1:0] pl_in,
	output logic          v_out,
	output logic [DW-1:0] rem_out,
	output logic [NW-1:0] quo_out,
	output logic [DW-1:0] d_out,
	output logic [PW-1:0] pl_out
);

	logic          v   [NW+1];
	logic [DW-1:0] rem [NW+1];
	logic [NW-1:0] num [NW+1];
	logic [NW-1:0] quo [NW+1];
	logic [DW-1:0] dv  [NW+1];
	logic [PW-1:0] pl  [NW+1];

	assign v[0]   = v_in;
	assign rem[0] = rem_in;
	assign num[0] = num_in;
	assign quo[0] = '0;
	assign dv[0]  = d_in;
	assign pl[0]  = pl_in;

	// Each cell hands its partial remainder to its neighbour every cycle that en is high.
	for (genvar i = 0; i < NW; i++) begin : g_cell
		cscd_div_cell #(.DW(DW), .NW(NW), .PW(PW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.v_in   (v[i]),
			.rem_in (rem[i]),
			.num_in (num[i]),
			.quo_in (quo[i]),
			.d_in   (dv[i]),
			.pl_in  (pl[i]),
			.v_out  (v[i+1]),
			.rem_out(rem[i+1]),
			.num_out(num[i+1]),
			.quo_out(quo[i+1]),
			.d_out  (dv[i+1]),
			.pl_out (pl[i+1])
		);
	end

	assign v_out   = v[NW];
	assign rem_out = rem[NW];
	assign quo_out = quo[NW];
	assign d_out   = dv[NW];
	assign pl_out  = pl[NW];

endmodule

FILE: src/cscd_serializer.sv
// Turns one request's divider parameters into its stream of register writes.
// Depends on cscd_pkg and the assertion macro header.
`include "clock_synth_divider_calc_defines.svh"
module cscd_serializer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load_v,
	input  cscd_pkg::ser_rec_t rec,
	input  logic               rst_en,
	input  logic               out_stall,
	output logic               ready,
	output logic               out_valid,
	output logic [7:0]         reg_addr,
	output logic [7:0]         reg_data,
	output logic               last
);

	logic               busy_q;
	logic [4:0]         idx_q;
	cscd_pkg::ser_rec_t rec_q;
	logic [4:0]         last_idx;
	logic               take;

	assign last_idx  = rst_en ? 5'd16 : 5'd15;
	assign out_valid = busy_q;
	assign last      = busy_q && (idx_q == last_idx);
	assign take      = out_valid && !out_stall;
	assign ready     = !busy_q || (take && last);

	// Walk the write index; pick up the next request as the last write leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (ready) begin
			busy_q <= load_v;
			idx_q  <= '0;
		end else if (take) begin
			idx_q <= idx_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load_v) begin
			rec_q <= rec;
		end
	end

	// Address and byte of the current write.
	always_comb begin
		reg_addr = '0;
		reg_data = '0;
		unique case (idx_q)
			5'd0: begin
				reg_addr = cscd_pkg::PLLA_BASE;
				reg_data = cscd_pkg::FRAC_DEN[15:8];
			end
			5'd1: begin
				reg_addr = cscd_pkg::PLLA_BASE + 8'd1;
				reg_data = cscd_pkg::FRAC_DEN[7:0];
			end
			5'd2: begin
				reg_addr = cscd_pkg::PLLA_BASE + 8'd2;
				reg_data = {6'b0, rec_q.p1[17:16]};
			end
			5'd3: begin
				reg_addr = cscd_pkg::PLLA_BASE + 8'd3;
				reg_data = rec_q.p1[15:8];
			end
			5'd4: begin
				reg_addr = cscd_pkg::PLLA_BASE + 8'd4;
				reg_data = rec_q.p1[7:0];
			end
			5'd5: begin
				reg_addr = cscd_pkg::PLLA_BASE + 8'd5;
				reg_data = cscd_pkg::FRAC_HI | {4'b0, rec_q.p2[19:16]};
			end
			5'd6: begin
				reg_addr = cscd_pkg::PLLA_BASE + 8'd6;
				reg_data = rec_q.p2[15:8];
			end
			5'd7: begin
				reg_addr = cscd_pkg::PLLA_BASE + 8'd7;
				reg_data = rec_q.p2[7:0];
			end
			5'd8: begin
				reg_addr = rec_q.base;
			end
			5'd9: begin
				reg_addr = rec_q.base + 8'd1;
				reg_data = 8'h01;
			end
			5'd10: begin
				reg_addr = rec_q.base + 8'd2;
				reg_data = {1'b0, rec_q.rlog, 2'b0, rec_q.mp1[17:16]};
			end
			5'd11: begin
				reg_addr = rec_q.base + 8'd3;
				reg_data = rec_q.mp1[15:8];
			end
			5'd12: begin
				reg_addr = rec_q.base + 8'd4;
				reg_data = rec_q.mp1[7:0];
			end
			5'd13: begin
				reg_addr = rec_q.base + 8'd5;
			end
			5'd14: begin
				reg_addr = rec_q.base + 8'd6;
			end
			5'd15: begin
				reg_addr = rec_q.base + 8'd7;
			end
			5'd16: begin
				reg_addr = cscd_pkg::RST_ADDR;
				reg_data = cscd_pkg::RST_PLLA;
			end
			default: begin
				reg_addr = '0;
				reg_data = '0;
			end
		endcase
	end

	// A write that is not the last is always followed by another.
	`CSCD_ASSERT_NEXT(a_stream_continues, out_valid && !out_stall && !last, out_valid)
	// The write index never runs past the end of the request.
	`CSCD_ASSERT(a_idx_range, busy_q |-> (idx_q <= last_idx))
	// With the reset write enabled, the request ends on the reset register.
	`CSCD_ASSERT(a_reset_tail, (last && rst_en) |-> (reg_addr == cscd_pkg::RST_ADDR))

endmodule

FILE: src/clock_synth_divider_calc.sv
// Top level of the clock synthesizer divider calculator.
// Depends on cscd_pkg, cscd_div_chain and cscd_serializer.
//
//  channel   direction  handshake            payload
//  input     in         in_valid/in_stall    channel, freq_hz
//  result    out        out_valid/out_stall  reg_addr, reg_data, last
//  config    in         cfg_wr_en            cfg_index, cfg_data
//
// Each request gives 16 or 17 writes, one per cycle while out_stall is low, so in
// steady state a new request is taken only as the serializer finishes the last one;
// the result serializer sets that pace. On its way to the first write an item passes
// three rows of division cells (30, 44, 20), three arithmetic stages and the serializer
// register. Reset clears all valid bits and restores the register defaults. A stalled
// result holds the whole row once a finished request is waiting for the serializer.
module clock_synth_divider_calc #(
	parameter int CHANNELS = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  channel,
	input  logic [31:0] freq_hz,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  reg_addr,
	output logic [7:0]  reg_data,
	output logic        last
);

	localparam logic [2:0] CH_MAX = 3'(CHANNELS - 1);

	logic [26:0] crystal_q;
	logic [31:0] min_hz_q;
	logic [31:0] max_hz_q;
	logic [11:0] div_min_q;
	logic [11:0] div_max_q;
	logic [7:0]  mult_min_q;
	logic [7:0]  mult_max_q;
	logic        rst_en_q;

	logic        en;
	logic        ser_ready;

	logic [2:0]  rlog_in;
	logic [31:0] f_in;
	logic [2:0]  ch_in;

	logic        v_s1;
	logic [7:0]  base_s1;
	logic [2:0]  rlog_s1;
	logic [31:0] f_s1;

	logic        d1_v;
	logic [31:0] d1_rem;
	logic [29:0] d1_quo;
	logic [31:0] d1_d;
	logic [10:0] d1_pl;

	logic [11:0] div_c;
	logic        v_s2;
	logic [43:0] vco_s2;
	logic [22:0] pl_s2;

	logic        d2_v;
	logic [26:0] d2_rem;
	logic [43:0] d2_quo;
	logic [26:0] d2_d;
	logic [22:0] d2_pl;

	logic [7:0]  a_c;
	logic        v_s3;
	logic [46:0] prod_s3;
	logic [31:0] pl_s3;

	logic        d3_v;
	logic [26:0] d3_rem;
	logic [19:0] d3_quo;
	logic [26:0] d3_d;
	logic [31:0] d3_pl;

	logic [19:0]        b_f;
	logic [26:0]        x_f;
	logic [20:0]        r_f;
	logic               ge_f;
	logic [7:0]         p1f_f;
	cscd_pkg::ser_rec_t rec_f;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crystal_q  <= 27'd25000000;
			min_hz_q   <= 32'd500000;
			max_hz_q   <= 32'd200000000;
			div_min_q  <= 12'd4;
			div_max_q  <= 12'd900;
			mult_min_q <= 8'd15;
			mult_max_q <= 8'd90;
			rst_en_q   <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cscd_pkg::cfg_idx_t'(cfg_index))
				cscd_pkg::CFG_CRYSTAL:  crystal_q  <= cfg_data[26:0];
				cscd_pkg::CFG_MIN_HZ:   min_hz_q   <= cfg_data;
				cscd_pkg::CFG_MAX_HZ:   max_hz_q   <= cfg_data;
				cscd_pkg::CFG_DIV_MIN:  div_min_q  <= cfg_data[11:0];
				cscd_pkg::CFG_DIV_MAX:  div_max_q  <= cfg_data[11:0];
				cscd_pkg::CFG_MULT_MIN: mult_min_q <= cfg_data[7:0];
				cscd_pkg::CFG_MULT_MAX: mult_max_q <= cfg_data[7:0];
				cscd_pkg::CFG_RST_EN:   rst_en_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// The whole row moves unless a finished request waits on a busy serializer.
	assign en       = !(d3_v && !ser_ready);
	assign in_stall = !en;

	// Output divider choice for low frequencies, scaling, frequency clamp and channel clamp.
	always_comb begin
		priority if (freq_hz < 32'd8000)   rlog_in = 3'd7;
		else if (freq_hz < 32'd16000)      rlog_in = 3'd6;
		else if (freq_hz < 32'd32000)      rlog_in = 3'd5;
		else if (freq_hz < 32'd64000)      rlog_in = 3'd4;
		else if (freq_hz < 32'd128000)     rlog_in = 3'd3;
		else if (freq_hz < 32'd256000)     rlog_in = 3'd2;
		else if (freq_hz < 32'd512000)     rlog_in = 3'd1;
		else                               rlog_in = 3'd0;
		f_in = freq_hz << rlog_in;
		if (f_in < min_hz_q) f_in = min_hz_q;
		if (f_in > max_hz_q) f_in = max_hz_q;
		ch_in = (channel > CH_MAX) ? CH_MAX : channel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= d1_v;
			v_s3 <= d2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			base_s1 <= cscd_pkg::MS_BASE + 8'(cscd_pkg::MS_STRIDE * {5'b0, ch_in});
			rlog_s1 <= rlog_in;
			f_s1    <= f_in;
		end
	end

	// Integer output divider: VCO target over the scaled frequency.
	cscd_div_chain #(.DW(32), .NW(30), .PW(11)) u_div_out (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (v_s1),
		.rem_in ('0),
		.num_in (cscd_pkg::VCO_TARGET),
		.d_in   (f_s1),
		.pl_in  ({base_s1, rlog_s1}),
		.v_out  (d1_v),
		.rem_out(d1_rem),
		.quo_out(d1_quo),
		.d_out  (d1_d),
		.pl_out (d1_pl)
	);

	// Divider clamp, made even, then the VCO frequency.
	always_comb begin
		div_c = (d1_quo > {18'b0, div_max_q}) ? div_max_q : d1_quo[11:0];
		if (div_c < div_min_q) div_c = div_min_q;
		div_c = {div_c[11:1], 1'b0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vco_s2 <= 44'(div_c) * 44'(d1_d);
			pl_s2  <= {d1_pl, div_c};
		end
	end

	// PLL multiplier: VCO frequency over the crystal, with remainder.
	cscd_div_chain #(.DW(27), .NW(44), .PW(23)) u_div_pll (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (v_s2),
		.rem_in ('0),
		.num_in (vco_s2),
		.d_in   (crystal_q),
		.pl_in  (pl_s2),
		.v_out  (d2_v),
		.rem_out(d2_rem),
		.quo_out(d2_quo),
		.d_out  (d2_d),
		.pl_out (d2_pl)
	);

	// Multiplier clamp and remainder scaled by the fraction denominator.
	always_comb begin
		a_c = (d2_quo > {36'b0, mult_max_q}) ? mult_max_q : d2_quo[7:0];
		if (a_c < mult_min_q) a_c = mult_min_q;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= {d2_rem, 20'b0} - {20'b0, d2_rem};
			pl_s3   <= {d2_pl, a_c, (d2_d == 27'd0)};
		end
	end

	// Fraction numerator: the top bits already sit below the crystal.
	cscd_div_chain #(.DW(27), .NW(20), .PW(32)) u_div_frac (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (v_s3),
		.rem_in (prod_s3[46:20]),
		.num_in (prod_s3[19:0]),
		.d_in   (crystal_q),
		.pl_in  (pl_s3),
		.v_out  (d3_v),
		.rem_out(d3_rem),
		.quo_out(d3_quo),
		.d_out  (d3_d),
		.pl_out (d3_pl)
	);

	// Split 128*b by the denominator 2^20-1 and pack P1, P2 and the multisynth P1.
	always_comb begin
		b_f   = d3_pl[0] ? 20'd0 : d3_quo;
		x_f   = {b_f, 7'b0};
		r_f   = {1'b0, x_f[19:0]} + {14'b0, x_f[26:20]};
		ge_f  = r_f >= {1'b0, cscd_pkg::FRAC_DEN};
		p1f_f = {1'b0, x_f[26:20]} + {7'b0, ge_f};
		rec_f.base = d3_pl[31:24];
		rec_f.rlog = d3_pl[23:21];
		rec_f.p2   = ge_f ? 20'(r_f - {1'b0, cscd_pkg::FRAC_DEN}) : r_f[19:0];
		rec_f.p1   = {3'b0, d3_pl[8:1], 7'b0} + {10'b0, p1f_f} - cscd_pkg::P1_OFFSET;
		rec_f.mp1  = {d3_pl[19:9], 7'b0} - cscd_pkg::P1_OFFSET;
	end

	cscd_serializer u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.load_v   (d3_v),
		.rec      (rec_f),
		.rst_en   (rst_en_q),
		.out_stall(out_stall),
		.ready    (ser_ready),
		.out_valid(out_valid),
		.reg_addr (reg_addr),
		.reg_data (reg_data),
		.last     (last)
	);

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the clock synthesizer divider calculator.
// Depends on cscd_pkg and clock_synth_divider_calc; predicts each register write.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NCH = 3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [2:0]  cfg_index = cscd_pkg::CFG_CRYSTAL;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  channel = '0;
	logic [31:0] freq_hz = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  reg_addr;
	logic [7:0]  reg_data;
	logic        last;

	typedef struct packed {
		logic [7:0] addr;
		logic [7:0] data;
		logic       last;
	} reg_write_t;

	// Shadow copy of the configuration registers.
	logic [26:0] crystal = 27'd25000000;
	logic [31:0] min_hz = 32'd500000;
	logic [31:0] max_hz = 32'd200000000;
	logic [11:0] div_min = 12'd4;
	logic [11:0] div_max = 12'd900;
	logic [7:0]  mult_min = 8'd15;
	logic [7:0]  mult_max = 8'd90;
	logic        rst_en = 1'b0;

	reg_write_t pending_writes[$];
	int errors = 0;
	int n_items = 0;
	int n_writes = 0;
	bit quiet = 1'b0;

	clock_synth_divider_calc #(.CHANNELS(NCH)) dut (.*);

	always #5 clk = ~clk;

	// Work out the register writes caused by one request.
	task automatic predict_writes(input logic [2:0] ch, input logic [31:0] fin);
		logic [63:0] f, dv, vco, a, b, rem;
		logic [2:0]  rlog;
		logic [31:0] p1, p2, p1f, mp1, ch_n;
		logic [7:0]  base;
		reg_write_t  w [$];
		f = fin;
		if (fin < 8000) rlog = 7;
		else if (fin < 16000) rlog = 6;
		else if (fin < 32000) rlog = 5;
		else if (fin < 64000) rlog = 4;
		else if (fin < 128000) rlog = 3;
		else if (fin < 256000) rlog = 2;
		else if (fin < 512000) rlog = 1;
		else rlog = 0;
		f = f << rlog;
		if (f < min_hz) f = min_hz;
		if (f > max_hz) f = max_hz;
		dv = (f == 0) ? 64'hFFFFFFFF : 64'd900000000 / f;
		if (dv > div_max) dv = div_max;
		if (dv < div_min) dv = div_min;
		dv[0] = 1'b0;
		vco = dv * f;
		if (crystal == 0) begin
			a = 64'hFFFFFFFF;
			b = 0;
		end else begin
			a = vco / crystal;
			rem = vco % crystal;
			b = (rem * 64'd1048575) / crystal;
		end
		if (a > mult_max) a = mult_max;
		if (a < mult_min) a = mult_min;
		p1f = 32'((64'd128 * b) / 64'd1048575);
		p2 = 32'(128 * b) - 32'd1048575 * p1f;
		p1 = 32'(128 * a) + p1f - 32'd512;
		w.push_back('{cscd_pkg::PLLA_BASE, 8'hFF, 1'b0});
		w.push_back('{cscd_pkg::PLLA_BASE + 8'd1, 8'hFF, 1'b0});
		w.push_back('{cscd_pkg::PLLA_BASE + 8'd2, {6'd0, p1[17:16]}, 1'b0});
		w.push_back('{cscd_pkg::PLLA_BASE + 8'd3, p1[15:8], 1'b0});
		w.push_back('{cscd_pkg::PLLA_BASE + 8'd4, p1[7:0], 1'b0});
		w.push_back('{cscd_pkg::PLLA_BASE + 8'd5, {4'hF, p2[19:16]}, 1'b0});
		w.push_back('{cscd_pkg::PLLA_BASE + 8'd6, p2[15:8], 1'b0});
		w.push_back('{cscd_pkg::PLLA_BASE + 8'd7, p2[7:0], 1'b0});
		ch_n = (ch > NCH - 1) ? NCH - 1 : ch;
		base = 8'(42 + 18 * ch_n);
		mp1 = 32'(128 * dv) - 32'd512;
		w.push_back('{base, 8'h00, 1'b0});
		w.push_back('{base + 8'd1, 8'h01, 1'b0});
		w.push_back('{base + 8'd2, {1'b0, rlog, 2'b00, mp1[17:16]}, 1'b0});
		w.push_back('{base + 8'd3, mp1[15:8], 1'b0});
		w.push_back('{base + 8'd4, mp1[7:0], 1'b0});
		for (int i = 5; i < 8; i++) w.push_back('{base + 8'(i), 8'h00, 1'b0});
		if (rst_en) w.push_back('{cscd_pkg::RST_ADDR, cscd_pkg::RST_PLLA, 1'b0});
		w[w.size() - 1].last = 1'b1;
		foreach (w[i]) pending_writes.push_back(w[i]);
	endtask

	// Send one request and wait for it to be accepted; valid drops only while idling.
	task automatic send_request(input logic [2:0] ch, input logic [31:0] f);
		while (!quiet && $urandom_range(99) < 13) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		predict_writes(ch, f);
		in_valid <= 1'b1;
		channel <= ch;
		freq_hz <= f;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		n_items++;
	endtask

	// Wait until every predicted write has come and the pipeline is quiet.
	task automatic drain;
		in_valid <= 1'b0;
		while (pending_writes.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	// One register write; the write enable then drops low again.
	task automatic write_cfg(input cscd_pkg::cfg_idx_t idx, input logic [31:0] v);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		unique case (idx)
			cscd_pkg::CFG_CRYSTAL:  crystal = v[26:0];
			cscd_pkg::CFG_MIN_HZ:   min_hz = v;
			cscd_pkg::CFG_MAX_HZ:   max_hz = v;
			cscd_pkg::CFG_DIV_MIN:  div_min = v[11:0];
			cscd_pkg::CFG_DIV_MAX:  div_max = v[11:0];
			cscd_pkg::CFG_MULT_MIN: mult_min = v[7:0];
			cscd_pkg::CFG_MULT_MAX: mult_max = v[7:0];
			cscd_pkg::CFG_RST_EN:   rst_en = v[0];
		endcase
	endtask

	task automatic restore_defaults;
		write_cfg(cscd_pkg::CFG_CRYSTAL, 25000000);
		write_cfg(cscd_pkg::CFG_MIN_HZ, 500000);
		write_cfg(cscd_pkg::CFG_MAX_HZ, 200000000);
		write_cfg(cscd_pkg::CFG_DIV_MIN, 4);
		write_cfg(cscd_pkg::CFG_DIV_MAX, 900);
		write_cfg(cscd_pkg::CFG_MULT_MIN, 15);
		write_cfg(cscd_pkg::CFG_MULT_MAX, 90);
		write_cfg(cscd_pkg::CFG_RST_EN, 0);
	endtask

	// Directed requests: frequency extremes, R band edges, every channel.
	task automatic test_directed;
		logic [31:0] edges [$] = '{0, 1, 7999, 8000, 15999, 16000, 31999, 32000, 64000,
			127999, 128000, 256000, 511999, 512000, 10000000, 225000000,
			32'hFFFFFFFF};
		foreach (edges[i]) send_request(3'(i), edges[i]);
		for (int c = 0; c < 8; c++) send_request(3'(c), 32'h5555AAAA ^ (c << 20));
		drain();
	endtask

	// Extreme register settings: crossed clamps, zero crystal, wrapping dividers.
	task automatic test_extreme_config;
		write_cfg(cscd_pkg::CFG_RST_EN, 1);
		write_cfg(cscd_pkg::CFG_CRYSTAL, 0);
		write_cfg(cscd_pkg::CFG_MAX_HZ, 0);
		write_cfg(cscd_pkg::CFG_MIN_HZ, 32'hFFFFFFFF);
		write_cfg(cscd_pkg::CFG_DIV_MIN, 12'hFFF);
		write_cfg(cscd_pkg::CFG_DIV_MAX, 0);
		write_cfg(cscd_pkg::CFG_MULT_MIN, 8'hFF);
		write_cfg(cscd_pkg::CFG_MULT_MAX, 0);
		send_request(3'd0, 32'd1000);
		send_request(3'd7, 32'hFFFFFFFF);
		drain();
		write_cfg(cscd_pkg::CFG_CRYSTAL, 27'h7FFFFFF);
		write_cfg(cscd_pkg::CFG_MIN_HZ, 0);
		write_cfg(cscd_pkg::CFG_MAX_HZ, 32'hFFFFFFFF);
		write_cfg(cscd_pkg::CFG_DIV_MIN, 0);
		write_cfg(cscd_pkg::CFG_DIV_MAX, 12'hFFF);
		write_cfg(cscd_pkg::CFG_MULT_MIN, 0);
		write_cfg(cscd_pkg::CFG_MULT_MAX, 8'hFF);
		for (int i = 0; i < 6; i++) send_request(3'($urandom), $urandom);
		send_request(3'd1, 32'd0);
		drain();
		write_cfg(cscd_pkg::CFG_CRYSTAL, 1000000);
		write_cfg(cscd_pkg::CFG_MULT_MIN, 1);
		for (int i = 0; i < 6; i++) send_request(3'($urandom), $urandom_range(600000000));
		drain();
		restore_defaults();
	endtask

	// Random requests under several random settings, one phase with no idling.
	task automatic test_random;
		for (int ph = 0; ph < 6; ph++) begin
			quiet = (ph == 2);
			if (ph > 0) begin
				write_cfg(cscd_pkg::CFG_CRYSTAL, $urandom_range(100000000, 1000000));
				write_cfg(cscd_pkg::CFG_MIN_HZ, $urandom_range(2000000));
				write_cfg(cscd_pkg::CFG_MAX_HZ, $urandom_range(300000000, 1000000));
				write_cfg(cscd_pkg::CFG_DIV_MIN, $urandom_range(64, 4));
				write_cfg(cscd_pkg::CFG_DIV_MAX, $urandom_range(2048, 4));
				write_cfg(cscd_pkg::CFG_MULT_MIN, $urandom_range(40, 1));
				write_cfg(cscd_pkg::CFG_MULT_MAX, $urandom_range(255, 20));
				write_cfg(cscd_pkg::CFG_RST_EN, $urandom_range(1));
			end
			for (int i = 0; i < 50; i++) begin
				case ($urandom_range(3))
					0: send_request(3'($urandom), $urandom);
					1: send_request(3'($urandom), $urandom_range(600000));
					default: send_request(3'($urandom), $urandom_range(250000000));
				endcase
			end
			drain();
		end
		quiet = 1'b0;
	endtask

	// Random stall on the result side.
	always @(posedge clk) out_stall <= !quiet && ($urandom_range(99) < 13);

	// Compare each accepted write with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			reg_write_t exp_w;
			n_writes++;
			if (pending_writes.size() == 0) begin
				$display("%0t: unexpected write addr %0d data %h", $time, reg_addr, reg_data);
				errors++;
			end else begin
				exp_w = pending_writes.pop_front();
				if (exp_w.addr !== reg_addr || exp_w.data !== reg_data ||
						exp_w.last !== last) begin
					$display("%0t: expected addr %0d data %h last %b, got %0d %h %b",
						$time, exp_w.addr, exp_w.data, exp_w.last, reg_addr, reg_data, last);
					errors++;
				end
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_extreme_config();
		test_random();
		if (pending_writes.size() != 0) errors++;
		$display("Sent %0d requests and checked %0d register writes", n_items, n_writes);
		$display("covering R bands, clamp extremes and random register settings.");
		if (errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

	initial begin
		#5ms;
		$display("FAIL");
		$finish;
	end
endmodule
